@@ hw/rtl/nfc_response_frame_deframer_macros.svh @@
// ----------------------------------------------------------------------------
// NFC response frame deframer assertion macros
// Shared property macros for the checker of the deframer.
// ----------------------------------------------------------------------------
`ifndef NFC_RESPONSE_FRAME_DEFRAMER_MACROS_SVH
`define NFC_RESPONSE_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NFC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NFC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/nfc_rdf_pkg.sv @@
// ----------------------------------------------------------------------------
// NFC response frame deframer package
// Types, result codes and frame byte constants shared by the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package nfc_rdf_pkg;

    localparam logic [7:0] BYTE_PRE   = 8'h00;
    localparam logic [7:0] BYTE_START = 8'hff;
    localparam logic [7:0] BYTE_TFI   = 8'hd5;

    localparam logic [7:0] COPY_LIMIT_RESET = 8'd254;

    localparam logic [1:0] KIND_BODY  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_PREAMBLE = 3'd1;
    localparam logic [2:0] ERR_LEN_LCS  = 3'd2;
    localparam logic [2:0] ERR_ACK_POST = 3'd3;
    localparam logic [2:0] ERR_TFI      = 3'd4;
    localparam logic [2:0] ERR_CHECKSUM = 3'd5;
    localparam logic [2:0] ERR_POST     = 3'd6;
    localparam logic [2:0] ERR_TIMEOUT  = 3'd7;

    typedef struct packed {
        logic       timed_out;
        logic [7:0] rx_data;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] error_code;
        logic [7:0] body_length;
        logic [7:0] byte_index;
        logic [7:0] body_byte;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/nfc_rdf_in_stage.sv @@
// ----------------------------------------------------------------------------
// NFC deframer input stage
// Registers one received word and holds it until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nfc_rdf_in_stage
    import nfc_rdf_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       item_valid,
    output item_t      item,
    input  wire logic  item_take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

@@ hw/rtl/nfc_rdf_parser.sv @@
// ----------------------------------------------------------------------------
// NFC deframer frame parser
// Frame state machine with length, checksum and body position tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module nfc_rdf_parser
    import nfc_rdf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       fire,
    input  wire item_t      item,
    input  wire logic [7:0] copy_limit,
    output logic            res_valid,
    output result_t         res
);

    localparam logic [3:0] PH_PRE0    = 4'd0;
    localparam logic [3:0] PH_PRE1    = 4'd1;
    localparam logic [3:0] PH_START   = 4'd2;
    localparam logic [3:0] PH_LEN     = 4'd3;
    localparam logic [3:0] PH_LCS     = 4'd4;
    localparam logic [3:0] PH_ACKPOST = 4'd5;
    localparam logic [3:0] PH_TFI     = 4'd6;
    localparam logic [3:0] PH_BODY    = 4'd7;
    localparam logic [3:0] PH_DCS     = 4'd8;
    localparam logic [3:0] PH_POST    = 4'd9;

    logic [3:0] phase_reg;
    logic [3:0] phase_next;
    logic [7:0] frame_len_reg;
    logic [7:0] frame_len_next;
    logic [7:0] body_count_reg;
    logic [7:0] body_count_next;
    logic [7:0] running_sum_reg;
    logic [7:0] running_sum_next;

    logic [7:0] rx;
    logic [7:0] lcs_sum;
    logic [7:0] dcs_sum;
    logic [7:0] body_sum;
    logic [7:0] count_inc;
    logic [7:0] len_m1;
    logic       fail;
    logic [2:0] fail_code;

    assign rx        = item.rx_data;
    assign lcs_sum   = frame_len_reg + rx;
    assign dcs_sum   = running_sum_reg + rx;
    assign body_sum  = running_sum_reg + rx;
    assign count_inc = body_count_reg + 8'd1;
    assign len_m1    = frame_len_reg - 8'd1;

    always_comb begin
        phase_next       = phase_reg;
        frame_len_next   = frame_len_reg;
        body_count_next  = body_count_reg;
        running_sum_next = running_sum_reg;
        fail             = 1'b0;
        fail_code        = ERR_NONE;
        res_valid        = 1'b0;
        res              = '0;

        if (item.timed_out) begin
            fail      = 1'b1;
            fail_code = ERR_TIMEOUT;
        end else begin
            unique case (phase_reg)
                PH_PRE0: begin
                    if (rx != BYTE_PRE) begin
                        fail      = 1'b1;
                        fail_code = ERR_PREAMBLE;
                    end else begin
                        phase_next = PH_PRE1;
                    end
                end
                PH_PRE1: begin
                    if (rx != BYTE_PRE) begin
                        fail      = 1'b1;
                        fail_code = ERR_PREAMBLE;
                    end else begin
                        phase_next = PH_START;
                    end
                end
                PH_START: begin
                    if (rx != BYTE_START) begin
                        fail      = 1'b1;
                        fail_code = ERR_PREAMBLE;
                    end else begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    frame_len_next = rx;
                    phase_next     = PH_LCS;
                end
                PH_LCS: begin
                    if (lcs_sum != 8'd0) begin
                        fail      = 1'b1;
                        fail_code = ERR_LEN_LCS;
                    end else if (frame_len_reg == 8'd0) begin
                        phase_next = PH_ACKPOST;
                    end else begin
                        phase_next = PH_TFI;
                    end
                end
                PH_ACKPOST: begin
                    if (rx != BYTE_PRE) begin
                        fail      = 1'b1;
                        fail_code = ERR_ACK_POST;
                    end else begin
                        phase_next       = PH_PRE0;
                        frame_len_next   = 8'd0;
                        body_count_next  = 8'd0;
                        running_sum_next = 8'd0;
                    end
                end
                PH_TFI: begin
                    if (rx != BYTE_TFI) begin
                        fail      = 1'b1;
                        fail_code = ERR_TFI;
                    end else begin
                        running_sum_next = rx;
                        body_count_next  = 8'd0;
                        phase_next       = (frame_len_reg == 8'd1) ? PH_DCS : PH_BODY;
                    end
                end
                PH_BODY: begin
                    running_sum_next = body_sum;
                    body_count_next  = count_inc;
                    if (count_inc >= len_m1) begin
                        phase_next = PH_DCS;
                    end
                    if (body_count_reg < copy_limit) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_BODY;
                        res.body_byte  = rx;
                        res.byte_index = body_count_reg;
                    end
                end
                PH_DCS: begin
                    if (dcs_sum != 8'd0) begin
                        fail      = 1'b1;
                        fail_code = ERR_CHECKSUM;
                    end else begin
                        phase_next = PH_POST;
                    end
                end
                PH_POST: begin
                    if (rx != BYTE_PRE) begin
                        fail      = 1'b1;
                        fail_code = ERR_POST;
                    end else begin
                        phase_next       = PH_PRE0;
                        frame_len_next   = 8'd0;
                        body_count_next  = 8'd0;
                        running_sum_next = 8'd0;
                        res_valid        = 1'b1;
                        res.kind         = KIND_DONE;
                        res.body_length  = len_m1;
                    end
                end
                default: begin
                    phase_next       = PH_PRE0;
                    frame_len_next   = 8'd0;
                    body_count_next  = 8'd0;
                    running_sum_next = 8'd0;
                end
            endcase
        end

        if (fail) begin
            phase_next       = PH_PRE0;
            frame_len_next   = 8'd0;
            body_count_next  = 8'd0;
            running_sum_next = 8'd0;
            res_valid        = 1'b1;
            res              = '0;
            res.kind         = KIND_ERROR;
            res.error_code   = fail_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_PRE0;
            frame_len_reg   <= 8'd0;
            body_count_reg  <= 8'd0;
            running_sum_reg <= 8'd0;
        end else if (fire) begin
            phase_reg       <= phase_next;
            frame_len_reg   <= frame_len_next;
            body_count_reg  <= body_count_next;
            running_sum_reg <= running_sum_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/nfc_rdf_out_stage.sv @@
// ----------------------------------------------------------------------------
// NFC deframer output stage
// Result register that holds a result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nfc_rdf_out_stage
    import nfc_rdf_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    output logic         space,
    input  wire logic    load,
    input  wire result_t load_res,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign space      = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= load_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

@@ hw/rtl/nfc_response_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// NFC response frame deframer
// Parses controller response frames from received serial bytes and passes
// on body bytes, a done word or an error word.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         received byte, timeout flag
//  m_axis    out        body byte / frame done / frame error
//  APB       in/out     copy_limit register at addresses 0 to 3
//
//  One word is accepted per cycle; each word passes the input register, the
//  frame state machine and the result register. Reset is synchronous and
//  active low and returns the parser to the preamble hunt with copy_limit at
//  COPY_LIMIT_INIT (254 by default). A stalled result holds the input register;
//  new words wait only while both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module nfc_response_frame_deframer
    import nfc_rdf_pkg::*;
#(
    parameter logic [7:0] COPY_LIMIT_INIT = COPY_LIMIT_RESET
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_data
    input  wire logic [0:0]  s_axis_tuser,   // [0] timed_out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] body_byte, [15:8] byte_index, [23:16] body_length, [26:24] error_code
    output logic [31:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0] copy_limit_reg;
    logic       cfg_write;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    space;
    logic    fire;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {24'd0, copy_limit_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            copy_limit_reg <= COPY_LIMIT_INIT;
        end else if (cfg_write) begin
            copy_limit_reg <= pwdata[7:0];
        end
    end

    assign in_item.rx_data   = s_axis_tdata;
    assign in_item.timed_out = s_axis_tuser[0];

    nfc_rdf_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (space)
    );

    assign fire = item_valid && space;

    nfc_rdf_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .item       (item),
        .copy_limit (copy_limit_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    nfc_rdf_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .space     (space),
        .load      (fire && res_valid),
        .load_res  (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {5'd0, out_res.error_code, out_res.body_length,
                           out_res.byte_index, out_res.body_byte};
    assign m_axis_tuser = out_res.kind;

endmodule

`default_nettype wire

@@ hw/rtl/nfc_rdf_checker.sv @@
// ----------------------------------------------------------------------------
// NFC deframer port checker
// Checks result words on the output port of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nfc_response_frame_deframer_macros.svh"

module nfc_rdf_checker
    import nfc_rdf_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    `NFC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `NFC_ASSERT_NOW(a_body_word, aclk, aresetn, m_axis_tvalid && (m_axis_tuser == KIND_BODY), m_axis_tdata[31:16] == 16'd0)
    `NFC_ASSERT_NOW(a_done_word, aclk, aresetn, m_axis_tvalid && (m_axis_tuser == KIND_DONE), (m_axis_tdata[15:0] == 16'd0) && (m_axis_tdata[31:24] == 8'd0))
    `NFC_ASSERT_NOW(a_error_word, aclk, aresetn, m_axis_tvalid && (m_axis_tuser == KIND_ERROR), (m_axis_tdata[23:0] == 24'd0) && (m_axis_tdata[26:24] != ERR_NONE) && (m_axis_tdata[31:27] == 5'd0))

endmodule

bind nfc_response_frame_deframer nfc_rdf_checker u_nfc_rdf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
